// ===== rtl/core/rlc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types, widths and helpers for the run-length compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package rlc_pkg;

  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 8;
  localparam int VB_W        = 3;
  localparam int PACK_N      = 4;
  localparam int PACK_AW     = 2;
  localparam int MAX_RUN_DEF = 127;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CODE,
    S_REP_CNT,
    S_REP_BYTE,
    S_LIT_HDR,
    S_LIT_DATA,
    S_FINAL,
    S_END
  } state_t;

  typedef enum logic {
    PH_LA,
    PH_LAST
  } phase_t;

  typedef enum logic [1:0] {
    RET_CODE,
    RET_DONE,
    RET_END
  } ret_t;

  // single literal is coded as a repeat of one, otherwise negated count
  function automatic cnt_t lit_header(input cnt_t len);
    cnt_t hdr;
    hdr = (len == CNT_W'(1)) ? CNT_W'(1) : (CNT_W'(0) - len);
    return hdr;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rle_literal_run_compressor_top.sv =====
// ----------------------------------------------------------------------------
// rle_literal_run_compressor_top
// PackBits-style compressor: byte frames in, packed run/literal tokens out.
// ----------------------------------------------------------------------------
// One byte is taken per input transaction and one item is processed at a
// time. A byte that is only held for lookahead is just stored; otherwise the
// accept is followed by coding each byte of the step. The final step of a
// frame codes the held byte, if any, and its own byte, then starts the
// frame-end flush. A single byte emitter serves both token kinds, and
// literal bytes come out of the literal memory at one read per cycle unless
// the emitter is held. A token that ends a literal or repeat run before the
// current byte is coded sends the block back to re-evaluate that byte, and
// a step that emitted bytes closes its last result in the end state. Output
// bytes are packed four per result; a finished result waits in an output
// register. While that register is stalled, the block holds whenever the
// packing register has to hand a result over: when it is full and another
// byte is ready, or at the end of a step.
// The literal memory needs no clearing after reset: only entries below the
// current literal count are ever read.
`default_nettype none

module rle_literal_run_compressor_top #(
  parameter int MAX_RUN = rlc_pkg::MAX_RUN_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [rlc_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                     in_frame_last,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [rlc_pkg::BYTE_W-1:0]    out_byte_0,
  output logic [rlc_pkg::BYTE_W-1:0]    out_byte_1,
  output logic [rlc_pkg::BYTE_W-1:0]    out_byte_2,
  output logic [rlc_pkg::BYTE_W-1:0]    out_byte_3,
  output logic [rlc_pkg::VB_W-1:0]      out_valid_bytes,
  output logic                          out_step_last,
  output logic                          out_frame_done
);

  localparam int AW = $clog2(MAX_RUN);

  rlc_pkg::state_t state_r, state_nxt;
  rlc_pkg::phase_t phase_r, phase_nxt;
  rlc_pkg::ret_t   ret_r, ret_nxt;

  rlc_pkg::byte_t d_r, d_nxt;
  logic           last_r, last_nxt;
  rlc_pkg::byte_t la_r, la_nxt;
  logic           la_valid_r, la_valid_nxt;
  rlc_pkg::byte_t run_byte_r, run_byte_nxt;
  rlc_pkg::cnt_t  run_len_r, run_len_nxt;
  logic           mode_r, mode_nxt;
  rlc_pkg::cnt_t  lit_len_r, lit_len_nxt;

  rlc_pkg::cnt_t  em_cnt_r, em_cnt_nxt;
  rlc_pkg::byte_t em_byte_r, em_byte_nxt;
  rlc_pkg::cnt_t  em_len_r, em_len_nxt;
  logic [AW-1:0]  lit_idx_r, lit_idx_nxt;

  rlc_pkg::byte_t lit_mem [MAX_RUN];
  rlc_pkg::byte_t rd_data_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  rlc_pkg::byte_t mem_wdata;

  rlc_pkg::byte_t            pack_r [rlc_pkg::PACK_N];
  rlc_pkg::byte_t            pack_nxt [rlc_pkg::PACK_N];
  logic [rlc_pkg::VB_W-1:0]  pack_cnt_r, pack_cnt_nxt;

  logic                      out_valid_r, out_valid_nxt;
  rlc_pkg::byte_t            out_b_r [rlc_pkg::PACK_N];
  rlc_pkg::byte_t            out_b_nxt [rlc_pkg::PACK_N];
  logic [rlc_pkg::VB_W-1:0]  out_vb_r, out_vb_nxt;
  logic                      out_sl_r, out_sl_nxt;
  logic                      out_fd_r, out_fd_nxt;

  logic           in_acc;
  rlc_pkg::byte_t cur_b;
  logic           has_next;
  logic           out_free;
  logic           byte_rdy;
  logic           emit_st;
  logic           byte_fire;
  rlc_pkg::byte_t emit_b;
  logic           lit_end;
  logic           emit_last;
  logic           rep_hit;
  logic           rep_full;
  logic           lit_match;
  logic           lit_full;
  logic           code_quiet;
  logic           phase_end;
  logic           pack_full;
  logic           push_full;
  logic           push_end;

  assign in_stall = (state_r != rlc_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign cur_b    = (phase_r == rlc_pkg::PH_LA) ? la_r : d_r;
  assign has_next = (phase_r == rlc_pkg::PH_LA);

  assign out_free  = !out_valid_r || !out_stall;
  assign pack_full = (pack_cnt_r == rlc_pkg::VB_W'(rlc_pkg::PACK_N));
  assign byte_rdy  = !pack_full || out_free;
  assign emit_st   = (state_r inside {rlc_pkg::S_REP_CNT, rlc_pkg::S_REP_BYTE,
                                      rlc_pkg::S_LIT_HDR, rlc_pkg::S_LIT_DATA});
  assign byte_fire = emit_st && byte_rdy;
  assign lit_end   = (rlc_pkg::CNT_W'(lit_idx_r) + rlc_pkg::CNT_W'(1) == em_len_r);
  assign emit_last = byte_fire && ((state_r == rlc_pkg::S_REP_BYTE) ||
                                   ((state_r == rlc_pkg::S_LIT_DATA) && lit_end));

  assign rep_hit    = (cur_b == run_byte_r);
  assign rep_full   = (run_len_r >= rlc_pkg::CNT_W'(MAX_RUN));
  assign lit_match  = has_next && (d_r == cur_b);
  assign lit_full   = (lit_len_r >= rlc_pkg::CNT_W'(MAX_RUN));
  assign code_quiet = (state_r == rlc_pkg::S_CODE) &&
                      (mode_r ? (rep_hit && !rep_full)
                              : (lit_match ? (lit_len_r == '0) : !lit_full));
  assign phase_end  = code_quiet || (emit_last && (ret_r == rlc_pkg::RET_DONE));

  assign push_full = byte_fire && pack_full;
  assign push_end  = (state_r == rlc_pkg::S_END) && (pack_cnt_r != '0) && out_free;

  always_comb begin
    case (state_r)
      rlc_pkg::S_REP_CNT:  emit_b = rlc_pkg::BYTE_W'(em_cnt_r);
      rlc_pkg::S_REP_BYTE: emit_b = em_byte_r;
      rlc_pkg::S_LIT_HDR:  emit_b = rlc_pkg::BYTE_W'(em_cnt_r);
      default:             emit_b = rd_data_r;
    endcase
  end

  // next state
  always_comb begin
    rlc_pkg::state_t end_tgt;
    rlc_pkg::state_t phase_tgt;
    end_tgt = ((pack_cnt_r == '0) && !byte_fire) ? rlc_pkg::S_IDLE : rlc_pkg::S_END;
    if (phase_r == rlc_pkg::PH_LAST) begin
      phase_tgt = rlc_pkg::S_FINAL;
    end else if (last_r) begin
      phase_tgt = rlc_pkg::S_CODE;
    end else begin
      phase_tgt = end_tgt;
    end
    state_nxt = state_r;
    case (state_r)
      rlc_pkg::S_IDLE: begin
        if (in_acc && (la_valid_r || in_frame_last)) begin
          state_nxt = rlc_pkg::S_CODE;
        end
      end
      rlc_pkg::S_CODE: begin
        if (phase_end) begin
          state_nxt = phase_tgt;
        end else if (mode_r) begin
          state_nxt = rlc_pkg::S_REP_CNT;
        end else begin
          state_nxt = rlc_pkg::S_LIT_HDR;
        end
      end
      rlc_pkg::S_REP_CNT: begin
        if (byte_fire) begin
          state_nxt = rlc_pkg::S_REP_BYTE;
        end
      end
      rlc_pkg::S_LIT_HDR: begin
        if (byte_fire) begin
          state_nxt = rlc_pkg::S_LIT_DATA;
        end
      end
      rlc_pkg::S_REP_BYTE, rlc_pkg::S_LIT_DATA: begin
        if (emit_last) begin
          case (ret_r)
            rlc_pkg::RET_CODE: state_nxt = rlc_pkg::S_CODE;
            rlc_pkg::RET_DONE: state_nxt = phase_tgt;
            default:           state_nxt = rlc_pkg::S_END;
          endcase
        end
      end
      rlc_pkg::S_FINAL: begin
        if (mode_r) begin
          state_nxt = rlc_pkg::S_REP_CNT;
        end else if (lit_len_r != '0) begin
          state_nxt = rlc_pkg::S_LIT_HDR;
        end else begin
          state_nxt = end_tgt;
        end
      end
      rlc_pkg::S_END: begin
        if ((pack_cnt_r == '0) || out_free) begin
          state_nxt = rlc_pkg::S_IDLE;
        end
      end
      default: state_nxt = rlc_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt    = phase_r;
    ret_nxt      = ret_r;
    d_nxt        = d_r;
    last_nxt     = last_r;
    la_nxt       = la_r;
    la_valid_nxt = la_valid_r;
    run_byte_nxt = run_byte_r;
    run_len_nxt  = run_len_r;
    mode_nxt     = mode_r;
    lit_len_nxt  = lit_len_r;
    em_cnt_nxt   = em_cnt_r;
    em_byte_nxt  = em_byte_r;
    em_len_nxt   = em_len_r;
    lit_idx_nxt  = lit_idx_r;
    mem_we       = 1'b0;
    mem_waddr    = lit_len_r[AW-1:0];
    mem_wdata    = cur_b;
    pack_nxt     = pack_r;
    pack_cnt_nxt = pack_cnt_r;
    out_b_nxt    = out_b_r;
    out_vb_nxt   = out_vb_r;
    out_sl_nxt   = out_sl_r;
    out_fd_nxt   = out_fd_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      rlc_pkg::S_IDLE: begin
        if (in_acc) begin
          d_nxt    = in_data_byte;
          last_nxt = in_frame_last;
          if (la_valid_r) begin
            phase_nxt = rlc_pkg::PH_LA;
          end else if (in_frame_last) begin
            phase_nxt = rlc_pkg::PH_LAST;
          end else begin
            la_nxt       = in_data_byte;
            la_valid_nxt = 1'b1;
          end
        end
      end
      rlc_pkg::S_CODE: begin
        if (mode_r) begin
          if (rep_hit && !rep_full) begin
            run_len_nxt = run_len_r + rlc_pkg::CNT_W'(1);
          end else if (rep_hit) begin
            em_cnt_nxt  = rlc_pkg::CNT_W'(MAX_RUN);
            em_byte_nxt = cur_b;
            run_len_nxt = rlc_pkg::CNT_W'(1);
            ret_nxt     = rlc_pkg::RET_DONE;
          end else begin
            em_cnt_nxt  = run_len_r;
            em_byte_nxt = run_byte_r;
            run_len_nxt = '0;
            mode_nxt    = 1'b0;
            lit_len_nxt = '0;
            ret_nxt     = rlc_pkg::RET_CODE;
          end
        end else if (code_quiet && lit_match) begin
          mode_nxt     = 1'b1;
          run_byte_nxt = cur_b;
          run_len_nxt  = rlc_pkg::CNT_W'(1);
        end else if (code_quiet) begin
          mem_we      = 1'b1;
          lit_len_nxt = lit_len_r + rlc_pkg::CNT_W'(1);
        end else begin
          em_len_nxt  = lit_len_r;
          em_cnt_nxt  = rlc_pkg::lit_header(lit_len_r);
          lit_len_nxt = '0;
          lit_idx_nxt = '0;
          ret_nxt     = rlc_pkg::RET_CODE;
        end
      end
      rlc_pkg::S_LIT_DATA: begin
        if (byte_fire) begin
          lit_idx_nxt = lit_end ? '0 : lit_idx_r + AW'(1);
        end
      end
      rlc_pkg::S_FINAL: begin
        em_cnt_nxt   = mode_r ? run_len_r : rlc_pkg::lit_header(lit_len_r);
        em_byte_nxt  = run_byte_r;
        em_len_nxt   = lit_len_r;
        lit_idx_nxt  = '0;
        ret_nxt      = rlc_pkg::RET_END;
        la_nxt       = '0;
        la_valid_nxt = 1'b0;
        run_byte_nxt = '0;
        run_len_nxt  = '0;
        mode_nxt     = 1'b0;
        lit_len_nxt  = '0;
      end
      default: begin
      end
    endcase

    if (phase_end && (phase_r == rlc_pkg::PH_LA)) begin
      if (last_r) begin
        phase_nxt = rlc_pkg::PH_LAST;
      end else begin
        la_nxt = d_r;
      end
    end

    if (push_full || push_end) begin
      out_b_nxt     = pack_r;
      out_vb_nxt    = pack_cnt_r;
      out_sl_nxt    = push_end;
      out_fd_nxt    = push_end && last_r;
      out_valid_nxt = 1'b1;
    end

    if (byte_fire) begin
      if ((pack_cnt_r == '0) || pack_full) begin
        for (int i = 1; i < rlc_pkg::PACK_N; i++) begin
          pack_nxt[i] = '0;
        end
        pack_nxt[0]  = emit_b;
        pack_cnt_nxt = rlc_pkg::VB_W'(1);
      end else begin
        pack_nxt[pack_cnt_r[rlc_pkg::PACK_AW-1:0]] = emit_b;
        pack_cnt_nxt = pack_cnt_r + rlc_pkg::VB_W'(1);
      end
    end else if (push_end) begin
      pack_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlc_pkg::S_IDLE;
      phase_r     <= rlc_pkg::PH_LA;
      ret_r       <= rlc_pkg::RET_CODE;
      la_r        <= '0;
      la_valid_r  <= 1'b0;
      run_byte_r  <= '0;
      run_len_r   <= '0;
      mode_r      <= 1'b0;
      lit_len_r   <= '0;
      lit_idx_r   <= '0;
      pack_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ret_r       <= ret_nxt;
      la_r        <= la_nxt;
      la_valid_r  <= la_valid_nxt;
      run_byte_r  <= run_byte_nxt;
      run_len_r   <= run_len_nxt;
      mode_r      <= mode_nxt;
      lit_len_r   <= lit_len_nxt;
      lit_idx_r   <= lit_idx_nxt;
      pack_cnt_r  <= pack_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r       <= d_nxt;
    last_r    <= last_nxt;
    em_cnt_r  <= em_cnt_nxt;
    em_byte_r <= em_byte_nxt;
    em_len_r  <= em_len_nxt;
    pack_r    <= pack_nxt;
    out_b_r   <= out_b_nxt;
    out_vb_r  <= out_vb_nxt;
    out_sl_r  <= out_sl_nxt;
    out_fd_r  <= out_fd_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lit_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= lit_mem[lit_idx_nxt];
  end

  assign out_valid       = out_valid_r;
  assign out_byte_0      = out_b_r[0];
  assign out_byte_1      = out_b_r[1];
  assign out_byte_2      = out_b_r[2];
  assign out_byte_3      = out_b_r[3];
  assign out_valid_bytes = out_vb_r;
  assign out_step_last   = out_sl_r;
  assign out_frame_done  = out_fd_r;

endmodule

`default_nettype wire

// ===== rtl/core/rlc_checker.sv =====
// ----------------------------------------------------------------------------
// rlc_checker
// Port-level checks on the compressor's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rlc_pkg::BYTE_W-1:0]  out_byte_0,
  input wire logic [rlc_pkg::BYTE_W-1:0]  out_byte_1,
  input wire logic [rlc_pkg::BYTE_W-1:0]  out_byte_2,
  input wire logic [rlc_pkg::BYTE_W-1:0]  out_byte_3,
  input wire logic [rlc_pkg::VB_W-1:0]    out_valid_bytes,
  input wire logic                        out_step_last,
  input wire logic                        out_frame_done
);

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_0) &&
      $stable(out_byte_1) && $stable(out_byte_2) && $stable(out_byte_3) &&
      $stable(out_valid_bytes) && $stable(out_step_last) && $stable(out_frame_done))
    else $error("stalled result changed");

  a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_bytes >= rlc_pkg::VB_W'(1)) &&
                  (out_valid_bytes <= rlc_pkg::VB_W'(rlc_pkg::PACK_N)))
    else $error("byte count out of range");

  a_full_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_step_last |-> out_valid_bytes == rlc_pkg::VB_W'(rlc_pkg::PACK_N))
    else $error("partial result before end of step");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_step_last)
    else $error("frame end without step end");

endmodule

bind rle_literal_run_compressor_top rlc_checker u_rlc_checker (.*);

`default_nettype wire

// ===== bench/rle_token_checker.sv =====
// ----------------------------------------------------------------------------
// rle_token_checker
// Watches both channels of the run-length compressor. Every accepted input
// byte is coded by a local PackBits-style encoder. The encoder keeps its own
// lookahead, repeat run and literal buffer. The bytes coded by that step are
// packed four per word and queued. Each accepted output word is compared
// field by field with the oldest queued word. The error count and the number
// of words still awaited are passed to the testbench top.
// ----------------------------------------------------------------------------

module rle_token_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  rlc_pkg::byte_t            in_data_byte,
  input  logic                      in_frame_last,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  rlc_pkg::byte_t            out_byte_0,
  input  rlc_pkg::byte_t            out_byte_1,
  input  rlc_pkg::byte_t            out_byte_2,
  input  rlc_pkg::byte_t            out_byte_3,
  input  logic [rlc_pkg::VB_W-1:0]  out_valid_bytes,
  input  logic                      out_step_last,
  input  logic                      out_frame_done,
  output int                        fail_cnt,
  output int                        awaited_cnt
);

  localparam int RUN_MAX = rlc_pkg::MAX_RUN_DEF;

  typedef struct {
    rlc_pkg::byte_t           bytes [rlc_pkg::PACK_N];
    logic [rlc_pkg::VB_W-1:0] nbytes;
    logic                     step_end;
    logic                     frame_end;
  } token_word_t;

  token_word_t    words_q[$];
  rlc_pkg::byte_t code_q[$];

  rlc_pkg::byte_t held_byte;
  logic           held_ok;
  rlc_pkg::byte_t rep_byte;
  int             rep_len;
  logic           rep_mode;
  rlc_pkg::byte_t lit_buf [RUN_MAX];
  int             lit_len;
  int             errs;

  function automatic void clear_encoder();
    held_byte = '0;
    held_ok   = 1'b0;
    rep_byte  = '0;
    rep_len   = 0;
    rep_mode  = 1'b0;
    lit_len   = 0;
  endfunction

  function automatic void flush_literal();
    int n;
    int i;
    n = (lit_len > RUN_MAX) ? RUN_MAX : lit_len;
    if (n > 1) begin
      code_q.push_back(rlc_pkg::byte_t'(0 - n));
      for (i = 0; i < n; i++) code_q.push_back(lit_buf[i]);
    end else if (n == 1) begin
      code_q.push_back(rlc_pkg::byte_t'(1));
      code_q.push_back(lit_buf[0]);
    end
    lit_len = 0;
  endfunction

  function automatic void flush_repeat();
    if (rep_len > 0) begin
      code_q.push_back(rlc_pkg::byte_t'(rep_len));
      code_q.push_back(rep_byte);
    end
    rep_len = 0;
  endfunction

  function automatic void code_byte(rlc_pkg::byte_t b, logic has_next,
                                    rlc_pkg::byte_t nxt);
    if (rep_mode) begin
      if (b == rep_byte) begin
        if (rep_len >= RUN_MAX) begin
          code_q.push_back(rlc_pkg::byte_t'(RUN_MAX));
          code_q.push_back(b);
          rep_len = 1;
        end else begin
          rep_len++;
        end
        return;
      end
      flush_repeat();
      rep_mode = 1'b0;
      lit_len  = 0;
    end
    if (has_next && nxt == b) begin
      flush_literal();
      rep_mode = 1'b1;
      rep_byte = b;
      rep_len  = 1;
      return;
    end
    if (lit_len >= RUN_MAX) flush_literal();
    lit_buf[lit_len] = b;
    lit_len++;
  endfunction

  function automatic void encode_step(rlc_pkg::byte_t d, logic last);
    token_word_t w;
    int nw;
    int k;
    int j;
    int base;
    int left;
    code_q.delete();
    if (held_ok) code_byte(held_byte, 1'b1, d);
    if (last) begin
      code_byte(d, 1'b0, '0);
      if (rep_mode) flush_repeat();
      else flush_literal();
      clear_encoder();
    end else begin
      held_byte = d;
      held_ok   = 1'b1;
    end
    nw = (code_q.size() + 3) / 4;
    for (k = 0; k < nw; k++) begin
      base = 4 * k;
      left = code_q.size() - base;
      for (j = 0; j < rlc_pkg::PACK_N; j++) begin
        w.bytes[j] = (j < left) ? code_q[base + j] : '0;
      end
      w.nbytes    = rlc_pkg::VB_W'((left > 4) ? 4 : left);
      w.step_end  = (k == nw - 1);
      w.frame_end = last && (k == nw - 1);
      words_q.push_back(w);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errs++;
    end
  endfunction

  initial begin
    errs = 0;
    clear_encoder();
  end

  always @(posedge clk) begin : watch
    token_word_t w;
    if (!rst_n) begin
      clear_encoder();
      words_q.delete();
    end else begin
      if (in_valid && !in_stall) encode_step(in_data_byte, in_frame_last);
      if (out_valid && !out_stall) begin
        if (words_q.size() == 0) begin
          $error("out_byte_0: expected none, actual %0h (no word awaited)", out_byte_0);
          errs++;
        end else begin
          w = words_q.pop_front();
          check_field("out_byte_0", w.bytes[0], out_byte_0);
          check_field("out_byte_1", w.bytes[1], out_byte_1);
          check_field("out_byte_2", w.bytes[2], out_byte_2);
          check_field("out_byte_3", w.bytes[3], out_byte_3);
          check_field("out_valid_bytes", 8'(w.nbytes), 8'(out_valid_bytes));
          check_field("out_step_last", 8'(w.step_end), 8'(out_step_last));
          check_field("out_frame_done", 8'(w.frame_end), 8'(out_frame_done));
        end
      end
    end
    fail_cnt    <= errs;
    awaited_cnt <= words_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the run-length compressor. A few short frames come first:
// single bytes, extreme values, short repeats and literals. Random frames
// follow, built from repeat runs, literal runs and near-equal noise. One
// frame holds a repeat run near the 127 chunk limit and one a literal run
// near it. Both channels idle at random, except for a calm stretch over the
// long repeat frame. The sender drains the block now and then. The checker
// gives the verdict count.
// ----------------------------------------------------------------------------

module tb_top;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  rlc_pkg::byte_t           in_data_byte = '0;
  logic                     in_frame_last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  rlc_pkg::byte_t           out_byte_0;
  rlc_pkg::byte_t           out_byte_1;
  rlc_pkg::byte_t           out_byte_2;
  rlc_pkg::byte_t           out_byte_3;
  logic [rlc_pkg::VB_W-1:0] out_valid_bytes;
  logic                     out_step_last;
  logic                     out_frame_done;
  int                       fail_cnt;
  int                       awaited_cnt;

  rlc_pkg::byte_t frame_bytes[$];
  logic           calm = 1'b0;
  int             frame_idx;
  int             sent_items;
  int             segs;
  int             kind;
  int             s;

  always #2 clk = ~clk;

  rle_literal_run_compressor_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_frame_last   (in_frame_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_0      (out_byte_0),
    .out_byte_1      (out_byte_1),
    .out_byte_2      (out_byte_2),
    .out_byte_3      (out_byte_3),
    .out_valid_bytes (out_valid_bytes),
    .out_step_last   (out_step_last),
    .out_frame_done  (out_frame_done)
  );

  rle_token_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_frame_last   (in_frame_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_0      (out_byte_0),
    .out_byte_1      (out_byte_1),
    .out_byte_2      (out_byte_2),
    .out_byte_3      (out_byte_3),
    .out_valid_bytes (out_valid_bytes),
    .out_step_last   (out_step_last),
    .out_frame_done  (out_frame_done),
    .fail_cnt        (fail_cnt),
    .awaited_cnt     (awaited_cnt)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  function automatic rlc_pkg::byte_t pick_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return rlc_pkg::byte_t'($urandom_range(255));
  endfunction

  function automatic void add_repeat(rlc_pkg::byte_t b, int n);
    int i;
    for (i = 0; i < n; i++) frame_bytes.push_back(b);
  endfunction

  // adjacent bytes differ, so the run stays literal
  function automatic void add_literal(int n);
    rlc_pkg::byte_t b;
    int i;
    for (i = 0; i < n; i++) begin
      b = pick_byte();
      if (frame_bytes.size() > 0 && b == frame_bytes[$]) b = b + 8'd1;
      frame_bytes.push_back(b);
    end
  endfunction

  function automatic void add_noise(int n);
    rlc_pkg::byte_t v;
    int i;
    v = pick_byte();
    for (i = 0; i < n; i++) begin
      frame_bytes.push_back(v ^ rlc_pkg::byte_t'($urandom_range(1)));
    end
  endfunction

  task automatic push_byte(input rlc_pkg::byte_t b, input logic last);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_frame_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    sent_items += frame_bytes.size();
    frame_bytes.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_cnt != 0) @(posedge clk);
  endtask

  initial begin
    sent_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    frame_bytes = '{8'h00};
    send_frame();
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{8'h00, 8'hFF};
    send_frame();
    frame_bytes = '{8'h5A, 8'h5A};
    send_frame();
    frame_bytes = '{8'h11, 8'h22, 8'h33, 8'h33, 8'h33, 8'h44};
    send_frame();
    frame_bytes = '{8'h80, 8'h80, 8'h7F, 8'h01, 8'h01};
    send_frame();
    frame_bytes = '{8'hAA, 8'h55, 8'hAA, 8'h55};
    send_frame();
    drain();

    frame_idx = 0;
    while (sent_items < 220 || frame_idx <= 2) begin
      calm = (frame_idx == 1);
      if (frame_idx == 1) begin
        add_literal($urandom_range(3));
        add_repeat(pick_byte(), $urandom_range(131, 126));
        add_literal($urandom_range(2));
      end else if (frame_idx == 2) begin
        add_literal($urandom_range(131, 126));
      end else begin
        segs = $urandom_range(5, 1);
        for (s = 0; s < segs; s++) begin
          kind = $urandom_range(99);
          if (kind < 45) add_repeat(pick_byte(), $urandom_range(8, 2));
          else if (kind < 85) add_literal($urandom_range(6, 1));
          else add_noise($urandom_range(6, 1));
        end
      end
      send_frame();
      if ($urandom_range(9) == 0) drain();
      frame_idx++;
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_cnt != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_cnt == 0 && awaited_cnt == 0) begin
      $display("rle_literal_run_compressor_top: match");
    end else begin
      $display("rle_literal_run_compressor_top: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("rle_literal_run_compressor_top: mismatch");
    $finish;
  end

endmodule
